/* rtl/core/okcd_pkg.sv */
// Shared types and constants of the ordered key chord detector.
`default_nettype none

package okcd_pkg;

	// number of key code registers and field widths
	localparam int CODE_REGS = 4;
	localparam int CODE_W    = 8;
	localparam int COUNT_W   = 3;
	localparam int HELD_W    = 4;

	// APB register map: one 32-bit word per register
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_KEY_CODE_0 = 3'd0;
	localparam reg_idx_t REG_KEY_CODE_1 = 3'd1;
	localparam reg_idx_t REG_KEY_CODE_2 = 3'd2;
	localparam reg_idx_t REG_KEY_CODE_3 = 3'd3;
	localparam reg_idx_t REG_KEY_COUNT  = 3'd4;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [HELD_W-1:0]  held_t;

	// order status
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_MATCHED = 2'd1,
		ST_BROKEN  = 2'd2
	} status_t;

endpackage

`default_nettype wire

/* rtl/core/okcd_if.sv */
// Word channels of the chord detector: held-key input and chord flag output.
`default_nettype none

interface okcd_key_if;
	logic                  valid;
	logic                  ready;
	okcd_pkg::held_t       keys_held;

	modport source (output valid, output keys_held, input ready);
	modport sink   (input valid, input keys_held, output ready);
endinterface

interface okcd_chord_if;
	logic valid;
	logic ready;
	logic chord_held;
	logic chord_down;
	logic chord_up;
	logic chord_released;

	modport source (output valid, output chord_held, output chord_down,
		output chord_up, output chord_released, input ready);
	modport sink   (input valid, input chord_held, input chord_down,
		input chord_up, input chord_released, output ready);
endinterface

`default_nettype wire

/* rtl/core/ordered_key_chord_detector_core.sv */
// Top level of the ordered key chord detector: APB registers, slot logic, word stages.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  keys    | in  | valid/ready        | keys_held[3:0]
//  chord   | out | valid/ready        | chord_held, chord_down, chord_up, chord_released
//  apb     | in  | psel/penable/pready| paddr[4:0], pwdata[31:0], prdata[31:0]
//
// A word is registered on entry, then the slot update runs combinationally into the
// output register; one word per cycle sustained while the output is not stalled.
// The slot update is a chain of up to four per-key steps over the order buffer.
// Reset empties the order buffer, sets the status to idle and the released flag.
// A stalled output holds its word; the entry stage keeps accepting while it can drain.
`default_nettype none

module ordered_key_chord_detector_core #(
	parameter int MAX_KEYS = 4
) (
	input  wire                           clk,
	input  wire                           arst_n,
	okcd_key_if.sink                      keys,
	okcd_chord_if.source                  chord,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [okcd_pkg::ADDR_W-1:0]    paddr,
	input  wire [okcd_pkg::DATA_W-1:0]    pwdata,
	output logic [okcd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// slots actually reachable: limited by both the buffer and the code registers
	localparam int Slots = (MAX_KEYS < okcd_pkg::CODE_REGS) ? MAX_KEYS : okcd_pkg::CODE_REGS;

	// configuration registers
	okcd_pkg::code_t  key_code_q [okcd_pkg::CODE_REGS];
	okcd_pkg::count_t key_count_q;

	// detector state
	okcd_pkg::code_t  buf_code_q [Slots];
	logic [Slots-1:0] buf_valid_q;
	okcd_pkg::status_t status_q;
	logic             was_released_q;

	// entry stage
	logic             valid_s1;
	okcd_pkg::held_t  held_s1;

	// output stage
	logic             out_valid_q;
	logic             out_held_q;
	logic             out_down_q;
	logic             out_up_q;
	logic             out_released_q;

	// next-state values
	okcd_pkg::code_t   buf_code_d [Slots];
	logic [Slots-1:0]  buf_valid_d;
	okcd_pkg::status_t status_d;
	logic              active;
	okcd_pkg::count_t  used_n;

	logic advance;
	logic cfg_wr;
	okcd_pkg::reg_idx_t reg_idx;

	assign reg_idx = paddr[okcd_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < okcd_pkg::CODE_REGS; i++) begin
				key_code_q[i] <= okcd_pkg::code_t'(1);
			end
			key_count_q <= okcd_pkg::count_t'(1);
		end else if (cfg_wr) begin
			if (reg_idx == okcd_pkg::REG_KEY_COUNT) begin
				key_count_q <= pwdata[okcd_pkg::COUNT_W-1:0];
			end else if (reg_idx == okcd_pkg::REG_KEY_CODE_0) begin
				key_code_q[0] <= pwdata[okcd_pkg::CODE_W-1:0];
			end else if (reg_idx == okcd_pkg::REG_KEY_CODE_1) begin
				key_code_q[1] <= pwdata[okcd_pkg::CODE_W-1:0];
			end else if (reg_idx == okcd_pkg::REG_KEY_CODE_2) begin
				key_code_q[2] <= pwdata[okcd_pkg::CODE_W-1:0];
			end else if (reg_idx == okcd_pkg::REG_KEY_CODE_3) begin
				key_code_q[3] <= pwdata[okcd_pkg::CODE_W-1:0];
			end
		end
	end

	// register reads
	always_comb begin
		prdata = '0;
		case (reg_idx)
			okcd_pkg::REG_KEY_CODE_0: prdata = okcd_pkg::DATA_W'(key_code_q[0]);
			okcd_pkg::REG_KEY_CODE_1: prdata = okcd_pkg::DATA_W'(key_code_q[1]);
			okcd_pkg::REG_KEY_CODE_2: prdata = okcd_pkg::DATA_W'(key_code_q[2]);
			okcd_pkg::REG_KEY_CODE_3: prdata = okcd_pkg::DATA_W'(key_code_q[3]);
			okcd_pkg::REG_KEY_COUNT:  prdata = okcd_pkg::DATA_W'(key_count_q);
			default:                  prdata = '0;
		endcase
	end

	// used key count: zero reads as one, clipped to the slot count
	always_comb begin
		used_n = (key_count_q == '0) ? okcd_pkg::count_t'(1) : key_count_q;
		if (used_n > okcd_pkg::count_t'(Slots)) begin
			used_n = okcd_pkg::count_t'(Slots);
		end
	end

	// handshake: the entry stage moves on when the output register is free or draining
	assign advance    = valid_s1 && (!out_valid_q || chord.ready);
	assign keys.ready = !valid_s1 || advance;

	// slot update: keys in configuration order, each a step on the buffer
	always_comb begin
		logic present;
		logic done;
		logic any_empty;
		logic all_empty;
		logic match;
		okcd_pkg::code_t code;

		buf_code_d  = buf_code_q;
		buf_valid_d = buf_valid_q;
		present     = 1'b0;
		done        = 1'b0;
		code        = '0;

		for (int i = 0; i < Slots; i++) begin
			if (okcd_pkg::count_t'(i) < used_n) begin
				code    = key_code_q[i];
				present = 1'b0;
				done    = 1'b0;
				if (held_s1[i]) begin
					for (int s = 0; s < Slots; s++) begin
						if (okcd_pkg::count_t'(s) < used_n && buf_valid_d[s]
								&& buf_code_d[s] == code) begin
							present = 1'b1;
						end
					end
					// first empty slot takes the code
					for (int s = 0; s < Slots; s++) begin
						if (!present && !done && okcd_pkg::count_t'(s) < used_n
								&& !buf_valid_d[s]) begin
							buf_valid_d[s] = 1'b1;
							buf_code_d[s]  = code;
							done           = 1'b1;
						end
					end
				end else begin
					// first slot holding the code is cleared
					for (int s = 0; s < Slots; s++) begin
						if (!done && okcd_pkg::count_t'(s) < used_n && buf_valid_d[s]
								&& buf_code_d[s] == code) begin
							buf_valid_d[s] = 1'b0;
							buf_code_d[s]  = '0;
							done           = 1'b1;
						end
					end
				end
			end
		end

		// summary over used slots
		any_empty = 1'b0;
		all_empty = 1'b1;
		match     = 1'b1;
		for (int s = 0; s < Slots; s++) begin
			if (okcd_pkg::count_t'(s) < used_n) begin
				if (buf_valid_d[s]) begin
					all_empty = 1'b0;
				end else begin
					any_empty = 1'b1;
				end
				if (!buf_valid_d[s] || buf_code_d[s] != key_code_q[s]) begin
					match = 1'b0;
				end
			end
		end

		// status transitions; an unknown code behaves as broken
		status_d = status_q;
		case (status_q)
			okcd_pkg::ST_IDLE: status_d = status_q;
			okcd_pkg::ST_MATCHED: begin
				if (any_empty) status_d = okcd_pkg::ST_BROKEN;
			end
			default: begin
				if (all_empty) status_d = okcd_pkg::ST_IDLE;
			end
		endcase

		active = 1'b0;
		if (match && (status_d == okcd_pkg::ST_IDLE || status_d == okcd_pkg::ST_MATCHED)) begin
			status_d = okcd_pkg::ST_MATCHED;
			active   = 1'b1;
		end
	end

	// entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.valid && keys.ready) begin
			held_s1 <= keys.keys_held;
		end
	end

	// detector state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q    <= '0;
			status_q       <= okcd_pkg::ST_IDLE;
			was_released_q <= 1'b1;
		end else if (advance) begin
			buf_valid_q    <= buf_valid_d;
			status_q       <= status_d;
			was_released_q <= !active;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buf_code_q <= buf_code_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (chord.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_held_q     <= active;
			out_down_q     <= active && was_released_q;
			out_up_q       <= !active && !was_released_q;
			out_released_q <= !active;
		end
	end

	assign chord.valid          = out_valid_q;
	assign chord.chord_held     = out_held_q;
	assign chord.chord_down     = out_down_q;
	assign chord.chord_up       = out_up_q;
	assign chord.chord_released = out_released_q;

endmodule

`default_nettype wire
